// ----- hw/rtl/bffa_pkg.sv -----
package bffa_pkg;

  // field widths fixed by the item formats
  localparam int FIELD_W  = 14;
  localparam int CFG_IDX_W = 2;

  // request modes
  localparam logic [1:0] MODE_ALLOC_INODE = 2'd0;
  localparam logic [1:0] MODE_ALLOC_BLOCK = 2'd1;
  localparam logic [1:0] MODE_FREE_INODE  = 2'd2;
  localparam logic [1:0] MODE_FREE_BLOCK  = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

  // reset value of both count registers
  localparam logic [FIELD_W-1:0] COUNT_RESET = 14'd8192;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [FIELD_W-1:0] entry_number;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] granted_number;
    logic [1:0]         status;
    logic [FIELD_W-1:0] free_left;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [FIELD_W-1:0]   value;
  } cfg_t;

endpackage

// ----- hw/rtl/bffa_chan_if.sv -----
interface bffa_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bitmap_first_free_allocator.sv -----
// Two-pool first-free allocator (inodes and blocks). Each pool is a bitmap of MAP_BITS
// entries held in a 32-bit wide single-port-write memory; MAP_BITS must be a multiple of
// 32. An allocate transaction is accepted, then scans the bitmap one 32-bit word per
// cycle, at most ceil(n/32) words where n = min(count, MAP_BITS). A free transaction is
// accepted, then does a read-modify-write of one word. After reset a clearing pass over
// all MAP_BITS/32 words zeroes both bitmaps; requests wait for it while configuration
// writes are taken. A finished result sits in an output register, so a new request is
// taken while it waits; a second finished result waits in a hold register.
module bitmap_first_free_allocator #(
  parameter int MAP_BITS = 8192
) (
  input  logic        clk,
  input  logic        rst,
  bffa_chan_if.sink   req,
  bffa_chan_if.source rsp,
  bffa_chan_if.sink   cfg
);

  localparam int WORDS = MAP_BITS / 32;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW    = AW + 5;
  localparam int MW    = (IW + 1 > bffa_pkg::FIELD_W) ? IW + 1 : bffa_pkg::FIELD_W;
  localparam int FW    = bffa_pkg::FIELD_W;

  // managed entries: count clipped to the map size
  function automatic logic [MW-1:0] managed(input logic [FW-1:0] count);
    logic [MW-1:0] c;
    c = MW'(count);
    return (c < MW'(MAP_BITS)) ? c : MW'(MAP_BITS);
  endfunction

  bffa_pkg::state_t state, state_next;

  logic [FW-1:0] inode_count, block_count;
  logic [FW-1:0] inodes_used, blocks_used;

  logic          pool;
  logic          bad;
  logic [4:0]    bit_sel;
  logic [AW-1:0] cur;

  logic            out_valid;
  bffa_pkg::rsp_t  out_data;
  bffa_pkg::rsp_t  hold;

  // bitmap memories
  logic [31:0]   imem [WORDS];
  logic [31:0]   bmem [WORDS];
  logic [31:0]   idata, bdata;
  logic [AW-1:0] raddr;
  logic [31:0]   wdata;
  logic          iwe, bwe;

  always_ff @(posedge clk) begin
    if (iwe) imem[cur] <= wdata;
    idata <= imem[raddr];
  end

  always_ff @(posedge clk) begin
    if (bwe) bmem[cur] <= wdata;
    bdata <= bmem[raddr];
  end

  // datapath
  logic [MW-1:0]  n, n_in, base, rem, next_base, e1, left, used_ext;
  logic [31:0]    rdata, vmask, cand, lowest;
  logic [4:0]     pos;
  logic           found, scan_end, free_ok, finish, success, out_free;
  logic [FW-1:0]  used_sel, used_new, count_in;
  logic [MW-1:0]  grant_ext;
  bffa_pkg::rsp_t fin;

  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    n         = managed(pool ? block_count : inode_count);
    count_in  = req.data.mode[0] ? block_count : inode_count;
    n_in      = managed(count_in);
    e1        = MW'(req.data.entry_number) - MW'(1);
    rdata     = pool ? bdata : idata;
    base      = MW'({cur, 5'b0});
    next_base = base + MW'(32);
    rem       = n - base;
    vmask     = (rem >= MW'(32)) ? '1 : ((32'd1 << rem[4:0]) - 32'd1);
    cand      = ~rdata & vmask;
    found     = |cand;
    lowest    = cand & (~cand + 32'd1);
    pos       = '0;
    for (int b = 0; b < 32; b++) begin
      if (lowest[b]) pos = pos | 5'(b);
    end
    scan_end  = found || (next_base >= n);
    free_ok   = !bad && rdata[bit_sel];
    used_sel  = pool ? blocks_used : inodes_used;
    grant_ext = base + MW'(pos) + MW'(1);

    success  = 1'b0;
    used_new = used_sel;
    fin      = '0;
    if (state == bffa_pkg::ST_SCAN) begin
      if (found) begin
        success            = 1'b1;
        used_new           = used_sel + FW'(1);
        fin.granted_number = grant_ext[FW-1:0];
        fin.status         = bffa_pkg::STATUS_OK;
      end else begin
        fin.status = bffa_pkg::STATUS_FULL;
      end
    end else begin
      if (free_ok) begin
        success  = 1'b1;
        used_new = (used_sel != '0) ? used_sel - FW'(1) : used_sel;
        fin.status = bffa_pkg::STATUS_OK;
      end else begin
        fin.status = bffa_pkg::STATUS_BAD_FREE;
      end
    end
    used_ext      = MW'(used_new);
    left          = (n > used_ext) ? n - used_ext : '0;
    fin.free_left = left[FW-1:0];
  end

  assign finish = ((state == bffa_pkg::ST_SCAN) && scan_end) || (state == bffa_pkg::ST_FREE);

  // memory control
  always_comb begin
    raddr = cur + AW'(1);
    iwe   = 1'b0;
    bwe   = 1'b0;
    wdata = '0;
    unique case (state)
      bffa_pkg::ST_CLEAR: begin
        iwe = 1'b1;
        bwe = 1'b1;
      end
      bffa_pkg::ST_IDLE: begin
        raddr = req.data.mode[1] ? e1[IW-1:5] : '0;
      end
      bffa_pkg::ST_SCAN: begin
        wdata = rdata | lowest;
        iwe   = found && !pool;
        bwe   = found && pool;
      end
      bffa_pkg::ST_FREE: begin
        wdata = rdata & ~(32'd1 << bit_sel);
        iwe   = free_ok && !pool;
        bwe   = free_ok && pool;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state) inside
      bffa_pkg::ST_CLEAR: if (cur == AW'(WORDS - 1)) state_next = bffa_pkg::ST_IDLE;
      bffa_pkg::ST_IDLE: begin
        if (req.valid) state_next = req.data.mode[1] ? bffa_pkg::ST_FREE : bffa_pkg::ST_SCAN;
      end
      bffa_pkg::ST_SCAN, bffa_pkg::ST_FREE: begin
        if (finish) state_next = out_free ? bffa_pkg::ST_IDLE : bffa_pkg::ST_WAIT;
      end
      bffa_pkg::ST_WAIT: if (out_free) state_next = bffa_pkg::ST_IDLE;
      default: state_next = bffa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bffa_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  assign req.ready = (state == bffa_pkg::ST_IDLE);
  assign cfg.ready = 1'b1;

  // word counter, per-transaction context
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else begin
      unique case (state)
        bffa_pkg::ST_CLEAR: cur <= cur + AW'(1);
        bffa_pkg::ST_IDLE:  cur <= req.data.mode[1] ? e1[IW-1:5] : '0;
        bffa_pkg::ST_SCAN:  if (!scan_end) cur <= cur + AW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      pool    <= req.data.mode[0];
      bad     <= (req.data.entry_number == '0) || (MW'(req.data.entry_number) > n_in);
      bit_sel <= e1[4:0];
    end
  end

  // configuration registers and used counters
  always_ff @(posedge clk) begin
    if (rst) begin
      inode_count <= bffa_pkg::COUNT_RESET;
      block_count <= bffa_pkg::COUNT_RESET;
      inodes_used <= '0;
      blocks_used <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.data.index)
          bffa_pkg::REG_INODE_COUNT: inode_count <= cfg.data.value;
          bffa_pkg::REG_BLOCK_COUNT: block_count <= cfg.data.value;
          default: ;
        endcase
      end
      if (finish && success) begin
        if (pool) blocks_used <= used_new;
        else      inodes_used <= used_new;
      end
    end
  end

  // output register and hold stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish && out_free) begin
      out_valid <= 1'b1;
    end else if ((state == bffa_pkg::ST_WAIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && out_free) out_data <= fin;
    else if ((state == bffa_pkg::ST_WAIT) && out_free) out_data <= hold;
    if (finish && !out_free) hold <= fin;
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule
